[src/gdcc_pkg.sv]
`default_nettype none

package gdcc_pkg;

  localparam int unsigned DefTableDepth = 128;
  localparam int unsigned DefNumberBits = 16;

  localparam int unsigned KindW   = 2;
  localparam int unsigned NumOutW = 16;
  localparam int unsigned CountW  = 8;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] CharVt    = 8'h0B;
  localparam logic [7:0] CharFf    = 8'h0C;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharG     = 8'h47;
  localparam logic [7:0] CharM     = 8'h4D;

  typedef enum logic [KindW-1:0] {
    KIND_G       = 2'd0,
    KIND_M       = 2'd1,
    KIND_UNKNOWN = 2'd2,
    KIND_SKIP    = 2'd3
  } kind_e;

  // Line-end request from the parser to the census engine.
  typedef struct packed {
    logic  valid;
    kind_e kind;
  } line_req_t;

endpackage

`default_nettype wire

[src/gdcc_ram.sv]
`default_nettype none

module gdcc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/gdcc_parser.sv]
`default_nettype none

module gdcc_parser #(
  parameter int unsigned NumberBits = gdcc_pkg::DefNumberBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  beat_i,
  input  wire logic [7:0]            text_byte_i,
  input  wire logic                  line_last_i,
  output gdcc_pkg::line_req_t        req_o,
  output logic signed [NumberBits-1:0] value_o
);
  import gdcc_pkg::*;

  localparam int unsigned MagW  = NumberBits - 1;
  localparam int unsigned ProdW = NumberBits + 3;
  localparam logic [MagW-1:0] MagLimit = {MagW{1'b1}};

  logic            started_q, started_d;
  kind_e           letter_q, letter_d;
  logic            sent_end_q, sent_end_d;
  logic            num_end_q, num_end_d;
  logic            neg_q, neg_d;
  logic            sign_q, sign_d;
  logic [MagW-1:0] mag_q, mag_d;

  logic             is_stop, is_digit, is_ws, line_end;
  logic [ProdW-1:0] prod;
  logic [NumberBits-1:0] mag_ext;

  assign is_stop  = (text_byte_i == CharNl) || (text_byte_i == CharSemi) ||
                    (text_byte_i == CharNul);
  assign is_digit = (text_byte_i >= CharZero) && (text_byte_i <= CharNine);
  assign is_ws    = (text_byte_i == CharTab) || (text_byte_i == CharVt) ||
                    (text_byte_i == CharFf) || (text_byte_i == CharCr);
  assign line_end = (text_byte_i == CharNl) || line_last_i;

  // mag * 10 + digit, never overflows ProdW
  assign prod = (ProdW'(mag_q) << 3) + (ProdW'(mag_q) << 1) + ProdW'(text_byte_i[3:0]);

  always_comb begin
    started_d  = started_q;
    letter_d   = letter_q;
    sent_end_d = sent_end_q;
    num_end_d  = num_end_q;
    neg_d      = neg_q;
    sign_d     = sign_q;
    mag_d      = mag_q;
    if (!started_q) begin
      started_d = 1'b1;
      if (is_stop) begin
        letter_d   = KIND_SKIP;
        sent_end_d = 1'b1;
        num_end_d  = 1'b1;
      end else if (text_byte_i == CharG) begin
        letter_d = KIND_G;
      end else if (text_byte_i == CharM) begin
        letter_d = KIND_M;
      end else begin
        letter_d = KIND_UNKNOWN;
      end
    end else if (!sent_end_q) begin
      if (is_stop) begin
        sent_end_d = 1'b1;
        num_end_d  = 1'b1;
      end else if (!num_end_q) begin
        if (text_byte_i == CharSpace) begin
          num_end_d = 1'b1;
        end else if (is_digit) begin
          mag_d  = (prod > ProdW'(MagLimit)) ? MagLimit : prod[MagW-1:0];
          sign_d = 1'b1;
        end else if (!sign_q && is_ws) begin
          // atoi skips leading whitespace
        end else if (!sign_q && ((text_byte_i == CharPlus) ||
                                 (text_byte_i == CharMinus))) begin
          neg_d  = (text_byte_i == CharMinus);
          sign_d = 1'b1;
        end else begin
          num_end_d = 1'b1;
        end
      end
    end
  end

  assign mag_ext     = {1'b0, mag_d};
  assign value_o     = neg_d ? (~mag_ext + NumberBits'(1)) : mag_ext;
  assign req_o.valid = beat_i && line_end && (letter_d != KIND_SKIP);
  assign req_o.kind  = letter_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      letter_q   <= KIND_G;
      sent_end_q <= 1'b0;
      num_end_q  <= 1'b0;
      neg_q      <= 1'b0;
      sign_q     <= 1'b0;
      mag_q      <= '0;
    end else if (beat_i) begin
      if (line_end) begin
        started_q  <= 1'b0;
        letter_q   <= KIND_G;
        sent_end_q <= 1'b0;
        num_end_q  <= 1'b0;
        neg_q      <= 1'b0;
        sign_q     <= 1'b0;
        mag_q      <= '0;
      end else begin
        started_q  <= started_d;
        letter_q   <= letter_d;
        sent_end_q <= sent_end_d;
        num_end_q  <= num_end_d;
        neg_q      <= neg_d;
        sign_q     <= sign_d;
        mag_q      <= mag_d;
      end
    end
  end

endmodule

`default_nettype wire

[src/gdcc_census.sv]
`default_nettype none

module gdcc_census #(
  parameter int unsigned TableDepth = gdcc_pkg::DefTableDepth,
  parameter int unsigned NumberBits = gdcc_pkg::DefNumberBits,
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1,
  localparam int unsigned CntW = $clog2(TableDepth + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire gdcc_pkg::line_req_t             req_i,
  input  wire logic signed [NumberBits-1:0]    value_i,
  output logic                                 idle_o,
  // table memory, G entries in the lower half, M in the upper
  output logic                                 ram_we_o,
  output logic [IdxW:0]                        ram_waddr_o,
  output logic [NumberBits-1:0]                ram_wdata_o,
  output logic                                 ram_re_o,
  output logic [IdxW:0]                        ram_raddr_o,
  input  wire logic [NumberBits-1:0]           ram_rdata_i,
  // result register
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [gdcc_pkg::KindW-1:0]           command_kind_o,
  output logic signed [gdcc_pkg::NumOutW-1:0] command_number_o,
  output logic                                 newly_added_o,
  output logic                                 table_full_o,
  output logic [gdcc_pkg::CountW-1:0]          g_distinct_o,
  output logic [gdcc_pkg::CountW-1:0]          m_distinct_o
);
  import gdcc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_RESP   = 3'b100
  } state_e;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  logic signed [NumberBits-1:0] value_q, value_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            cmp_q, cmp_d;
  logic            added_q, added_d;
  logic            full_q, full_d;
  logic [CntW-1:0] g_cnt_q, g_cnt_d;
  logic [CntW-1:0] m_cnt_q, m_cnt_d;

  logic            out_valid_q, out_valid_d;
  logic [KindW-1:0]         kind_out_q;
  logic signed [NumOutW-1:0] num_out_q;
  logic            added_out_q, full_out_q;
  logic [CountW-1:0] g_out_q, m_out_q;

  logic            is_m, load;
  logic [CntW-1:0] n;
  logic signed [31:0] value_wide;

  assign is_m = (kind_q == KIND_M);
  assign n    = is_m ? m_cnt_q : g_cnt_q;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    value_d     = value_q;
    idx_d       = idx_q;
    cmp_d       = 1'b0;
    added_d     = added_q;
    full_d      = full_q;
    g_cnt_d     = g_cnt_q;
    m_cnt_d     = m_cnt_q;
    ram_re_o    = 1'b0;
    ram_we_o    = 1'b0;
    load        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d  = req_i.kind;
          value_d = value_i;
          idx_d   = '0;
          added_d = 1'b0;
          full_d  = 1'b0;
          state_d = (req_i.kind == KIND_UNKNOWN) ? S_RESP : S_SEARCH;
        end
      end
      S_SEARCH: begin
        // one read issued per cycle, its data compared in the next cycle
        if (cmp_q && (ram_rdata_i == value_q)) begin
          state_d = S_RESP;
        end else if ((idx_q >= n) && !cmp_q) begin
          if (n == CntW'(TableDepth)) begin
            full_d = 1'b1;
          end else begin
            ram_we_o = 1'b1;
            added_d  = 1'b1;
            if (is_m) begin
              m_cnt_d = m_cnt_q + CntW'(1);
            end else begin
              g_cnt_d = g_cnt_q + CntW'(1);
            end
          end
          state_d = S_RESP;
        end else if (idx_q < n) begin
          ram_re_o = 1'b1;
          idx_d    = idx_q + CntW'(1);
          cmp_d    = 1'b1;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ram_raddr_o = {is_m, idx_q[IdxW-1:0]};
  assign ram_waddr_o = {is_m, n[IdxW-1:0]};
  assign ram_wdata_o = value_q;
  assign idle_o      = (state_q == S_IDLE);

  assign value_wide  = 32'(value_q);
  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmp_q       <= 1'b0;
      g_cnt_q     <= '0;
      m_cnt_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_q       <= cmp_d;
      g_cnt_q     <= g_cnt_d;
      m_cnt_q     <= m_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
    idx_q   <= idx_d;
    added_q <= added_d;
    full_q  <= full_d;
    if (load) begin
      kind_out_q  <= kind_q;
      num_out_q   <= (kind_q == KIND_UNKNOWN) ? '0 : value_wide[NumOutW-1:0];
      added_out_q <= added_q;
      full_out_q  <= full_q;
      g_out_q     <= CountW'(g_cnt_q);
      m_out_q     <= CountW'(m_cnt_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign command_kind_o   = kind_out_q;
  assign command_number_o = num_out_q;
  assign newly_added_o    = added_out_q;
  assign table_full_o     = full_out_q;
  assign g_distinct_o     = g_out_q;
  assign m_distinct_o     = m_out_q;

endmodule

`default_nettype wire

[src/gcode_distinct_command_census_core.sv]
// G/M command census over a byte stream of G-code text.
// Input channel: one text byte per beat (text_byte_i, line_last_i) under
//   in_valid_i / in_ready_o. A line closes on newline or on a beat with
//   line_last_i set; lines starting with newline, ';' or NUL give nothing.
// Output channel: one result beat per line under out_valid_o / out_ready_i:
//   kind, saturated number, inserted / table-full flags, both distinct counts.
// Flow: a byte that does not close a line is taken without a stall. A closing
//   byte of a G or M line starts a linear search of that letter's table,
//   one read of the shared table RAM per cycle (no read when the table is
//   empty), then the result moves into the output register; unknown lines
//   skip the search.
// in_ready_o is low while a search runs or a finished result waits for the
//   output register; a result held in the output register does not block
//   new bytes. A stalled receiver holds the output beat steady.
// Reset clears the line parser and both counts; table RAM is not cleared,
//   only entries below the count are ever read.
// A write happens only when a search ends, and the next search starts only
//   after the S_RESP and S_IDLE states, so RAM accesses never collide.
`default_nettype none

module gcode_distinct_command_census_core #(
  parameter int unsigned TableDepth = gdcc_pkg::DefTableDepth,
  parameter int unsigned NumberBits = gdcc_pkg::DefNumberBits
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [7:0]                      text_byte_i,
  input  wire logic                            line_last_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [gdcc_pkg::KindW-1:0]           command_kind_o,
  output logic signed [gdcc_pkg::NumOutW-1:0] command_number_o,
  output logic                                 newly_added_o,
  output logic                                 table_full_o,
  output logic [gdcc_pkg::CountW-1:0]          g_distinct_o,
  output logic [gdcc_pkg::CountW-1:0]          m_distinct_o
);
  import gdcc_pkg::*;

  localparam int unsigned IdxW     = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned RamDepth = 2 ** (IdxW + 1);

  logic                          beat;
  line_req_t                     req;
  logic signed [NumberBits-1:0]  value;
  logic                          idle;
  logic                          ram_we, ram_re;
  logic [IdxW:0]                 ram_waddr, ram_raddr;
  logic [NumberBits-1:0]         ram_wdata, ram_rdata;

  assign in_ready_o = idle;
  assign beat       = in_valid_i && idle;

  gdcc_parser #(
    .NumberBits(NumberBits)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_i     (beat),
    .text_byte_i(text_byte_i),
    .line_last_i(line_last_i),
    .req_o      (req),
    .value_o    (value)
  );

  gdcc_census #(
    .TableDepth(TableDepth),
    .NumberBits(NumberBits)
  ) u_census (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req),
    .value_i         (value),
    .idle_o          (idle),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .command_kind_o  (command_kind_o),
    .command_number_o(command_number_o),
    .newly_added_o   (newly_added_o),
    .table_full_o    (table_full_o),
    .g_distinct_o    (g_distinct_o),
    .m_distinct_o    (m_distinct_o)
  );

  gdcc_ram #(
    .Width(NumberBits),
    .Depth(RamDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

`default_nettype wire
